### sv/bdlp_pkg.sv
package bdlp_pkg;

	localparam int unsigned DEB_W   = 4;
	localparam int unsigned HOLD_W  = 32;
	localparam int unsigned TIME_W  = 48;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [DEB_W-1:0]  DEBOUNCE_COUNT_RESET = DEB_W'(2);
	localparam logic [HOLD_W-1:0] LONG_PRESS_US_RESET  = HOLD_W'(1500000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE_COUNT = 2'd0,
		CFG_LONG_PRESS_US  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic level_event;
		logic level_now;
		logic verdict_event;
		logic verdict_long;
	} result_t;

endpackage

### sv/button_debounce_long_press_core.sv
// Debounces a polled button level and classifies each press as short or long.
// One poll per transaction; a new poll is taken every cycle while out_ready allows,
// and each one yields exactly one result, passing through the input register and
// then the result register. The debounce counter, press timestamp and long-press flag update
// in the single pass from the input register to the result register, so back
// to back polls see each other's effect with no bubble. A poll with
// sample_valid low leaves the state alone and reports the current level.
// Hold time is now_us minus the press time, wrapping modulo 2^48, compared
// against long_press_us; the long verdict fires once per press and suppresses
// the short verdict on release. Configuration: index 0 debounce_count,
// index 1 long_press_us, other indexes ignored; write only while idle.
module button_debounce_long_press_core
	import bdlp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  sample_valid,
	input  logic                  raw_pressed,
	input  logic [TIME_W-1:0]     now_us,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  level_event,
	output logic                  level_now,
	output logic                  verdict_event,
	output logic                  verdict_long
);

	logic [DEB_W-1:0]  debounce_count_q;
	logic [HOLD_W-1:0] long_press_us_q;

	logic              stable_level_q;
	logic [DEB_W-1:0]  agree_counter_q;
	logic [TIME_W-1:0] press_start_q;
	logic              long_done_q;

	logic              valid_s1;
	logic              sample_valid_s1;
	logic              raw_s1;
	logic [TIME_W-1:0] now_s1;

	logic              valid_s2;
	result_t           res_s2;

	logic              advance;
	logic              fire;

	logic              differs;
	logic [DEB_W-1:0]  cnt_inc;
	logic              flip;
	logic              level_nx;
	logic [DEB_W-1:0]  counter_nx;
	logic [TIME_W-1:0] start_nx;
	logic              done_mid;
	logic              done_nx;
	logic [TIME_W-1:0] elapsed;
	logic              long_hit;
	result_t           res_nx;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_count_q <= DEBOUNCE_COUNT_RESET;
			long_press_us_q  <= LONG_PRESS_US_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_COUNT: debounce_count_q <= cfg_wdata[DEB_W-1:0];
				CFG_LONG_PRESS_US:  long_press_us_q  <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_valid_s1 <= sample_valid;
			raw_s1          <= raw_pressed;
			now_s1          <= now_us;
		end
	end

	always_comb begin
		differs    = raw_s1 != stable_level_q;
		cnt_inc    = agree_counter_q + DEB_W'(1);
		flip       = differs && (cnt_inc >= debounce_count_q);
		level_nx   = stable_level_q;
		counter_nx = agree_counter_q;
		start_nx   = press_start_q;
		done_mid   = long_done_q;
		res_nx     = '0;
		if (sample_valid_s1) begin
			if (!differs) begin
				counter_nx = '0;
			end else if (!flip) begin
				counter_nx = cnt_inc;
			end else begin
				counter_nx         = '0;
				level_nx           = raw_s1;
				res_nx.level_event = 1'b1;
				if (raw_s1) begin
					start_nx = now_s1;
					done_mid = 1'b0;
				end else if (!long_done_q) begin
					res_nx.verdict_event = 1'b1;
				end
			end
		end
		// hold time against the press start, wrapping
		elapsed  = now_s1 - start_nx;
		long_hit = sample_valid_s1 && level_nx && !done_mid &&
			(elapsed >= {{(TIME_W-HOLD_W){1'b0}}, long_press_us_q});
		done_nx  = done_mid || long_hit;
		if (long_hit) begin
			res_nx.verdict_event = 1'b1;
			res_nx.verdict_long  = 1'b1;
		end
		res_nx.level_now = level_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_level_q  <= 1'b0;
			agree_counter_q <= '0;
			press_start_q   <= '0;
			long_done_q     <= 1'b0;
		end else if (fire) begin
			stable_level_q  <= level_nx;
			agree_counter_q <= counter_nx;
			press_start_q   <= start_nx;
			long_done_q     <= done_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_nx;
		end
	end

	assign out_valid     = valid_s2;
	assign level_event   = res_s2.level_event;
	assign level_now     = res_s2.level_now;
	assign verdict_event = res_s2.verdict_event;
	assign verdict_long  = res_s2.verdict_long;

	a_long_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict_long |-> verdict_event)
		else $error("long verdict without verdict event");

	a_long_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict_long |-> level_now)
		else $error("long verdict while released");

	a_short_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict_event && !verdict_long |-> level_event && !level_now)
		else $error("short verdict outside a release edge");

	a_fire_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed poll produced no result");

endmodule
